// ===== hw/rtl/ppf_pkg.sv =====
// Shared constants, codes, command and status types for the polyline path follower.
package ppf_pkg;

    localparam int MAX_POINTS = 256;
    localparam int ADDR_W     = 8;
    localparam int CNT_W      = 9;
    localparam int COORD_W    = 16;
    localparam int DIFF_W     = 17;
    localparam int FRAC_W     = 8;
    localparam int LEN_W      = 34;
    localparam int TRAV_W     = 36;
    localparam int VEL_W      = 24;
    localparam int TS_W       = 16;
    localparam int POS_W      = 24;
    localparam int ROOT_W     = 25;
    localparam int RAD_W      = 50;
    localparam int REM_W      = 27;
    localparam int PROD_W     = 50;
    localparam int QUO_W      = 24;
    localparam int ADV_W      = 41;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_ADVANCE = 2'd1;
    localparam logic [1:0] REQ_REVERSE = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic capture;
        logic decode;
        logic sq_x;
        logic sq_y;
        logic root_step;
        logic write_pt;
        logic adv_mul;
        logic adv_add;
        logic reverse;
        logic init;
        logic probe;
        logic compare;
        logic rd_a;
        logic rd_b;
        logic cap_b;
        logic calc;
        logic mul_step;
        logic div_load;
        logic div_step;
        logic load_out;
    } ppf_cmd_t;

    typedef struct packed {
        logic is_load;
        logic is_adv;
        logic is_rev;
        logic full;
        logic new_route;
        logic root_done;
        logic empty;
        logic search_go;
        logic mid_seg;
        logic mul_done;
        logic div_done;
    } ppf_stat_t;

    function automatic logic signed [TRAV_W-1:0] sat_trav(input logic signed [TRAV_W+1:0] v);
        logic signed [TRAV_W+1:0] hi;
        logic signed [TRAV_W+1:0] lo;
        hi = (TRAV_W+2)'({1'b0, {(TRAV_W-1){1'b1}}});
        lo = -hi - (TRAV_W+2)'(1);
        if (v > hi)
        begin
            return hi[TRAV_W-1:0];
        end
        else if (v < lo)
        begin
            return lo[TRAV_W-1:0];
        end
        return v[TRAV_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/polyline_path_follower.sv =====
// Top level of the polyline path follower: stream ports, controller and datapath.
//
//   Channel | Direction | Handshake          | Contents
//   s_      | in        | s_tvalid/s_tready  | one request item per beat
//   m_      | out       | m_tvalid/m_tready  | one result item per beat
//   cfg_    | in        | cfg_valid/cfg_ready| velocity register write
//
// An item on an empty route goes from decode through init to output. A load that extends
// a route adds squares and a square root, the search runs a probe and a compare per step,
// and a point inside a segment adds multiply steps, a divider load and the divide,
// one quotient bit per cycle.
// Reset clears the route, travel distance, direction flag and velocity at once.
// A new item is taken while an earlier result still waits on m_tready.
module polyline_path_follower
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [47:0]                      s_tdata,  // way_x, way_y, time_step
    input  logic [2:0]                       s_tuser,  // req_type, first_point
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [119:0]                     m_tdata,  // pos_x, pos_y, dir_x, dir_y,
                                                       // distance_left, status, zero pad
    output logic [0:0]                       m_tuser,  // route_finished
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ppf_pkg::VEL_W-1:0]        cfg_data
);

    ppf_pkg::ppf_cmd_t  cmd;
    ppf_pkg::ppf_stat_t stat;

    logic signed [ppf_pkg::POS_W-1:0]  pos_x;
    logic signed [ppf_pkg::POS_W-1:0]  pos_y;
    logic signed [ppf_pkg::DIFF_W-1:0] dir_x;
    logic signed [ppf_pkg::DIFF_W-1:0] dir_y;
    logic                              route_finished;
    logic [ppf_pkg::LEN_W-1:0]         distance_left;
    logic [1:0]                        status;

    assign cfg_ready = 1'b1;

    ppf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ppf_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_valid),
        .cfg_velocity   ($signed(cfg_data)),
        .in_req_type    (s_tuser[1:0]),
        .in_way_x       ($signed(s_tdata[15:0])),
        .in_way_y       ($signed(s_tdata[31:16])),
        .in_first_point (s_tuser[2]),
        .in_time_step   (s_tdata[47:32]),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .dir_x          (dir_x),
        .dir_y          (dir_y),
        .route_finished (route_finished),
        .distance_left  (distance_left),
        .status         (status)
    );

    assign m_tdata = {2'b00, status, distance_left, dir_y, dir_x, pos_y, pos_x};
    assign m_tuser = route_finished;

endmodule

// ===== hw/rtl/ppf_ctrl.sv =====
// Controller state machine that sequences update, search, interpolation and output.
module ppf_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  ppf_pkg::ppf_stat_t stat,
    output ppf_pkg::ppf_cmd_t  cmd
);

    typedef enum logic [19:0] {
        ST_IDLE   = 20'h00001,
        ST_DECODE = 20'h00002,
        ST_SQX    = 20'h00004,
        ST_SQY    = 20'h00008,
        ST_ROOT   = 20'h00010,
        ST_WRITE  = 20'h00020,
        ST_ADVM   = 20'h00040,
        ST_ADVA   = 20'h00080,
        ST_REV    = 20'h00100,
        ST_INIT   = 20'h00200,
        ST_PROBE  = 20'h00400,
        ST_CMP    = 20'h00800,
        ST_RDA    = 20'h01000,
        ST_RDB    = 20'h02000,
        ST_CAPB   = 20'h04000,
        ST_CALC   = 20'h08000,
        ST_MUL    = 20'h10000,
        ST_DIVLD  = 20'h20000,
        ST_DIV    = 20'h40000,
        ST_FIN    = 20'h80000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.capture   = (state_reg == ST_IDLE) && in_valid;
        cmd.decode    = (state_reg == ST_DECODE);
        cmd.sq_x      = (state_reg == ST_SQX);
        cmd.sq_y      = (state_reg == ST_SQY);
        cmd.root_step = (state_reg == ST_ROOT);
        cmd.write_pt  = (state_reg == ST_WRITE);
        cmd.adv_mul   = (state_reg == ST_ADVM);
        cmd.adv_add   = (state_reg == ST_ADVA);
        cmd.reverse   = (state_reg == ST_REV);
        cmd.init      = (state_reg == ST_INIT);
        cmd.probe     = (state_reg == ST_PROBE);
        cmd.compare   = (state_reg == ST_CMP);
        cmd.rd_a      = (state_reg == ST_RDA);
        cmd.rd_b      = (state_reg == ST_RDB);
        cmd.cap_b     = (state_reg == ST_CAPB);
        cmd.calc      = (state_reg == ST_CALC);
        cmd.mul_step  = (state_reg == ST_MUL);
        cmd.div_load  = (state_reg == ST_DIVLD);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.load_out  = (state_reg == ST_FIN) && slot_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (stat.is_load && stat.full)
                begin
                    state_next = ST_INIT;
                end
                else if (stat.is_load && stat.new_route)
                begin
                    state_next = ST_WRITE;
                end
                else if (stat.is_load)
                begin
                    state_next = ST_SQX;
                end
                else if (stat.is_adv)
                begin
                    state_next = ST_ADVM;
                end
                else if (stat.is_rev)
                begin
                    state_next = ST_REV;
                end
                else
                begin
                    state_next = ST_INIT;
                end
            end
            ST_SQX:   state_next = ST_SQY;
            ST_SQY:   state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (stat.root_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: state_next = ST_INIT;
            ST_ADVM:  state_next = ST_ADVA;
            ST_ADVA:  state_next = ST_INIT;
            ST_REV:   state_next = ST_INIT;
            ST_INIT:  state_next = stat.empty ? ST_FIN : ST_PROBE;
            ST_PROBE: state_next = stat.search_go ? ST_CMP : ST_RDA;
            ST_CMP:   state_next = ST_PROBE;
            ST_RDA:   state_next = ST_RDB;
            ST_RDB:   state_next = ST_CAPB;
            ST_CAPB:  state_next = ST_CALC;
            ST_CALC:  state_next = stat.mid_seg ? ST_MUL : ST_FIN;
            ST_MUL:
            begin
                if (stat.mul_done)
                begin
                    state_next = ST_DIVLD;
                end
            end
            ST_DIVLD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted beat did not start decode");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while held");

    a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside the finish state");

endmodule

// ===== hw/rtl/ppf_dp.sv =====
// Datapath: waypoint memories, square root, travel update, search, multiply and divide.
module ppf_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ppf_pkg::ppf_cmd_t                   cmd,
    output ppf_pkg::ppf_stat_t                  stat,
    input  logic                                cfg_we,
    input  logic signed [ppf_pkg::VEL_W-1:0]    cfg_velocity,
    input  logic [1:0]                          in_req_type,
    input  logic signed [ppf_pkg::COORD_W-1:0]  in_way_x,
    input  logic signed [ppf_pkg::COORD_W-1:0]  in_way_y,
    input  logic                                in_first_point,
    input  logic [ppf_pkg::TS_W-1:0]            in_time_step,
    output logic signed [ppf_pkg::POS_W-1:0]    pos_x,
    output logic signed [ppf_pkg::POS_W-1:0]    pos_y,
    output logic signed [ppf_pkg::DIFF_W-1:0]   dir_x,
    output logic signed [ppf_pkg::DIFF_W-1:0]   dir_y,
    output logic                                route_finished,
    output logic [ppf_pkg::LEN_W-1:0]           distance_left,
    output logic [1:0]                          status
);

    localparam int AW = ppf_pkg::ADDR_W;
    localparam int CW = ppf_pkg::CNT_W;
    localparam int XW = ppf_pkg::COORD_W;
    localparam int DW = ppf_pkg::DIFF_W;
    localparam int LW = ppf_pkg::LEN_W;
    localparam int TW = ppf_pkg::TRAV_W;
    localparam int PW = ppf_pkg::POS_W;
    localparam int QW = ppf_pkg::QUO_W;
    localparam int MW = ppf_pkg::PROD_W;
    localparam int RW = ppf_pkg::ROOT_W;
    localparam int NW = ppf_pkg::RAD_W;
    localparam int EW = ppf_pkg::REM_W;
    localparam int FW = ppf_pkg::FRAC_W;
    localparam int HW = LW / 2;

    // Item and configuration registers.
    logic [1:0]               req_reg;
    logic signed [XW-1:0]     wx_reg;
    logic signed [XW-1:0]     wy_reg;
    logic                     first_reg;
    logic [ppf_pkg::TS_W-1:0] ts_reg;
    logic signed [ppf_pkg::VEL_W-1:0] vel_reg;

    // Route state.
    logic [CW-1:0]        cnt_reg;
    logic signed [TW-1:0] trav_reg;
    logic                 rev_reg;
    logic [LW-1:0]        total_reg;
    logic signed [XW-1:0] last_x_reg;
    logic signed [XW-1:0] last_y_reg;
    logic                 full_reg;

    // Segment length.
    logic [LW-1:0] sq_reg;
    logic [NW-1:0] rad_reg;
    logic [EW-1:0] rem_reg;
    logic [RW-1:0] root_reg;
    logic [4:0]    rcnt_reg;

    // Travel update.
    logic signed [ppf_pkg::ADV_W-1:0] adv_reg;

    // Search and endpoint fetch.
    logic [CW-1:0]        lo_reg;
    logic [CW-1:0]        hi_reg;
    logic [XW-1:0]        x_mem [ppf_pkg::MAX_POINTS];
    logic [XW-1:0]        y_mem [ppf_pkg::MAX_POINTS];
    logic [LW-1:0]        c_mem [ppf_pkg::MAX_POINTS];
    logic [XW-1:0]        rx_reg;
    logic [XW-1:0]        ry_reg;
    logic [LW-1:0]        rc_reg;
    logic signed [XW-1:0] ax_reg;
    logic signed [XW-1:0] ay_reg;
    logic [LW-1:0]        al_reg;
    logic signed [XW-1:0] bx_reg;
    logic signed [XW-1:0] by_reg;
    logic [LW-1:0]        bl_reg;

    // Interpolation.
    logic signed [DW-1:0] dx_reg;
    logic signed [DW-1:0] dy_reg;
    logic [LW-1:0]        num_reg;
    logic [LW-1:0]        den_reg;
    logic                 mid_reg;
    logic                 fin_reg;
    logic [1:0]           mcnt_reg;
    logic [MW-1:0]        px_reg;
    logic [MW-1:0]        py_reg;
    logic [LW-1:0]        remx_reg;
    logic [LW-1:0]        remy_reg;
    logic [QW-1:0]        qx_reg;
    logic [QW-1:0]        qy_reg;
    logic [4:0]           dcnt_reg;

    // Result register.
    logic signed [PW-1:0] opx_reg;
    logic signed [PW-1:0] opy_reg;
    logic signed [DW-1:0] odx_reg;
    logic signed [DW-1:0] ody_reg;
    logic                 ofin_reg;
    logic [LW-1:0]        oleft_reg;
    logic [1:0]           ostat_reg;

    // Combinational helpers.
    logic                 is_load;
    logic [CW-1:0]        mid_idx;
    logic [CW-1:0]        ia_idx;
    logic [CW-1:0]        ib_idx;
    logic [CW-1:0]        log_idx;
    logic [CW-1:0]        phys_idx;
    logic [LW-1:0]        lval;
    logic                 l_below;
    logic signed [DW-1:0] ex;
    logic signed [DW-1:0] ey;
    logic [XW-1:0]        mag_ex;
    logic [XW-1:0]        mag_ey;
    logic [EW+1:0]        rem4;
    logic [EW+1:0]        trial;
    logic                 root_ge;
    logic [LW:0]          cum_sum;
    logic [LW-1:0]        cum_new;
    logic signed [TW+1:0] adv_sum;
    logic signed [TW+1:0] rev_diff;
    logic [XW-1:0]        mag_dx;
    logic [XW-1:0]        mag_dy;
    logic [XW-1:0]        mul_a;
    logic [HW-1:0]        mul_b;
    logic [XW+HW-1:0]     mul_p;
    logic [LW:0]          rx2;
    logic [LW:0]          ry2;
    logic                 gex;
    logic                 gey;
    logic signed [TW-1:0] num_wide;
    logic signed [TW+1:0] left_diff;
    logic [LW-1:0]        left_val;
    logic signed [PW-1:0] base_x;
    logic signed [PW-1:0] base_y;
    logic signed [PW-1:0] ipx;
    logic signed [PW-1:0] ipy;

    assign is_load = (req_reg == ppf_pkg::REQ_LOAD);

    assign stat.is_load   = is_load;
    assign stat.is_adv    = (req_reg == ppf_pkg::REQ_ADVANCE);
    assign stat.is_rev    = (req_reg == ppf_pkg::REQ_REVERSE);
    assign stat.full      = !first_reg && (cnt_reg == CW'(ppf_pkg::MAX_POINTS));
    assign stat.new_route = first_reg || (cnt_reg == '0);
    assign stat.root_done = (rcnt_reg == 5'(RW - 1));
    assign stat.empty     = (cnt_reg == '0);
    assign stat.search_go = (lo_reg < hi_reg);
    assign stat.mid_seg   = (lo_reg != '0) && (lo_reg != cnt_reg);
    assign stat.mul_done  = (mcnt_reg == 2'd3);
    assign stat.div_done  = (dcnt_reg == 5'(QW - 1));

    // Logical to stored index, and the logical cumulative length of the read entry.
    assign mid_idx = CW'((CW+1)'(lo_reg) + (CW+1)'(hi_reg) >> 1);
    assign ia_idx  = (lo_reg == '0) ? '0 : lo_reg - CW'(1);
    assign ib_idx  = (lo_reg == '0) ? CW'(1) : lo_reg;

    always_comb
    begin
        priority if (cmd.rd_a)
        begin
            log_idx = ia_idx;
        end
        else if (cmd.rd_b)
        begin
            log_idx = ib_idx;
        end
        else
        begin
            log_idx = mid_idx;
        end
    end

    assign phys_idx = rev_reg ? (cnt_reg - CW'(1) - log_idx) : log_idx;
    assign lval     = rev_reg ? (total_reg - rc_reg) : rc_reg;
    assign l_below  = $signed({2'b00, lval}) < trav_reg;

    // Segment length: squares, then one root bit per cycle.
    assign ex     = DW'(wx_reg) - DW'(last_x_reg);
    assign ey     = DW'(wy_reg) - DW'(last_y_reg);
    assign mag_ex = ex[DW-1] ? XW'(-ex) : XW'(ex);
    assign mag_ey = ey[DW-1] ? XW'(-ey) : XW'(ey);
    assign rem4   = {rem_reg, rad_reg[NW-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign root_ge = (rem4 >= trial);

    assign cum_sum = {1'b0, total_reg} + (LW+1)'(root_reg);
    assign cum_new = (cnt_reg == '0) ? '0 :
                     ((cum_sum > {1'b0, ppf_pkg::LEN_MAX}) ? ppf_pkg::LEN_MAX : cum_sum[LW-1:0]);

    assign adv_sum  = (TW+2)'(trav_reg) + (TW+2)'(adv_reg >>> FW);
    assign rev_diff = $signed({4'b0000, total_reg}) - (TW+2)'(trav_reg);

    // Offset multiply: one 16 by 17 product per cycle.
    assign mag_dx = dx_reg[DW-1] ? XW'(-dx_reg) : XW'(dx_reg);
    assign mag_dy = dy_reg[DW-1] ? XW'(-dy_reg) : XW'(dy_reg);
    assign mul_a  = mcnt_reg[1] ? mag_dy : mag_dx;
    assign mul_b  = mcnt_reg[0] ? num_reg[LW-1:HW] : num_reg[HW-1:0];
    assign mul_p  = mul_a * mul_b;

    // Restoring divide, x and y share the divisor.
    assign rx2 = {remx_reg, qx_reg[QW-1]};
    assign ry2 = {remy_reg, qy_reg[QW-1]};
    assign gex = (rx2 >= {1'b0, den_reg});
    assign gey = (ry2 >= {1'b0, den_reg});

    assign num_wide  = trav_reg - $signed({2'b00, al_reg});
    assign left_diff = $signed({4'b0000, total_reg}) - (TW+2)'(trav_reg);
    assign left_val  = left_diff[TW+1] ? '0 :
                       ((left_diff > $signed({4'b0000, ppf_pkg::LEN_MAX})) ?
                        ppf_pkg::LEN_MAX : left_diff[LW-1:0]);

    assign base_x = {ax_reg, {FW{1'b0}}};
    assign base_y = {ay_reg, {FW{1'b0}}};
    assign ipx = !mid_reg ? base_x : (dx_reg[DW-1] ? base_x - $signed(qx_reg) : base_x + $signed(qx_reg));
    assign ipy = !mid_reg ? base_y : (dy_reg[DW-1] ? base_y - $signed(qy_reg) : base_y + $signed(qy_reg));

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg  <= '0;
            cnt_reg  <= '0;
            trav_reg <= '0;
            rev_reg  <= 1'b0;
            rcnt_reg <= '0;
            lo_reg   <= '0;
            hi_reg   <= '0;
            mcnt_reg <= '0;
            dcnt_reg <= '0;
            full_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vel_reg <= cfg_velocity;
            end
            if (cmd.decode)
            begin
                full_reg <= stat.is_load && stat.full;
                if (is_load && first_reg)
                begin
                    cnt_reg  <= '0;
                    trav_reg <= '0;
                    rev_reg  <= 1'b0;
                end
            end
            if (cmd.sq_y)
            begin
                rcnt_reg <= '0;
            end
            if (cmd.root_step)
            begin
                rcnt_reg <= rcnt_reg + 5'd1;
            end
            if (cmd.write_pt)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.adv_add)
            begin
                trav_reg <= ppf_pkg::sat_trav(adv_sum);
            end
            if (cmd.reverse && (cnt_reg != '0))
            begin
                trav_reg <= ppf_pkg::sat_trav(rev_diff);
                rev_reg  <= !rev_reg;
            end
            if (cmd.init)
            begin
                lo_reg <= '0;
                hi_reg <= cnt_reg;
            end
            if (cmd.compare)
            begin
                if (l_below)
                begin
                    lo_reg <= mid_idx + CW'(1);
                end
                else
                begin
                    hi_reg <= mid_idx;
                end
            end
            if (cmd.calc)
            begin
                mcnt_reg <= '0;
            end
            if (cmd.mul_step)
            begin
                mcnt_reg <= mcnt_reg + 2'd1;
            end
            if (cmd.div_load)
            begin
                dcnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + 5'd1;
            end
        end
    end

    // Waypoint and length memories with registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.write_pt)
        begin
            x_mem[cnt_reg[AW-1:0]] <= wx_reg;
            y_mem[cnt_reg[AW-1:0]] <= wy_reg;
            c_mem[cnt_reg[AW-1:0]] <= cum_new;
        end
        rx_reg <= x_mem[phys_idx[AW-1:0]];
        ry_reg <= y_mem[phys_idx[AW-1:0]];
        rc_reg <= c_mem[phys_idx[AW-1:0]];
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= in_req_type;
            wx_reg    <= in_way_x;
            wy_reg    <= in_way_y;
            first_reg <= in_first_point;
            ts_reg    <= in_time_step;
        end
        if (cmd.sq_x)
        begin
            sq_reg <= LW'(mag_ex * mag_ex);
        end
        if (cmd.sq_y)
        begin
            rad_reg  <= {sq_reg + LW'(mag_ey * mag_ey), {(NW-LW){1'b0}}};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.root_step)
        begin
            rem_reg  <= root_ge ? EW'(rem4 - trial) : EW'(rem4);
            root_reg <= {root_reg[RW-2:0], root_ge};
            rad_reg  <= {rad_reg[NW-3:0], 2'b00};
        end
        if (cmd.write_pt)
        begin
            total_reg  <= cum_new;
            last_x_reg <= wx_reg;
            last_y_reg <= wy_reg;
        end
        if (cmd.adv_mul)
        begin
            adv_reg <= vel_reg * $signed({1'b0, ts_reg});
        end
        if (cmd.rd_b)
        begin
            ax_reg <= rx_reg;
            ay_reg <= ry_reg;
            al_reg <= lval;
        end
        if (cmd.cap_b)
        begin
            bx_reg <= rx_reg;
            by_reg <= ry_reg;
            bl_reg <= lval;
        end
        if (cmd.calc)
        begin
            if ((lo_reg != cnt_reg) && (cnt_reg > CW'(1)))
            begin
                dx_reg <= DW'(bx_reg) - DW'(ax_reg);
                dy_reg <= DW'(by_reg) - DW'(ay_reg);
            end
            else
            begin
                dx_reg <= '0;
                dy_reg <= '0;
            end
            num_reg <= num_wide[LW-1:0];
            den_reg <= bl_reg - al_reg;
            mid_reg <= stat.mid_seg;
            fin_reg <= (lo_reg == cnt_reg);
        end
        if (cmd.mul_step)
        begin
            unique case (mcnt_reg)
                2'd0:    px_reg <= MW'(mul_p);
                2'd1:    px_reg <= px_reg + {mul_p, {HW{1'b0}}};
                2'd2:    py_reg <= MW'(mul_p);
                default: py_reg <= py_reg + {mul_p, {HW{1'b0}}};
            endcase
        end
        if (cmd.div_load)
        begin
            remx_reg <= px_reg[MW-1:MW-LW];
            remy_reg <= py_reg[MW-1:MW-LW];
            qx_reg   <= {px_reg[MW-LW-1:0], {FW{1'b0}}};
            qy_reg   <= {py_reg[MW-LW-1:0], {FW{1'b0}}};
        end
        if (cmd.div_step)
        begin
            remx_reg <= gex ? LW'(rx2 - {1'b0, den_reg}) : rx2[LW-1:0];
            remy_reg <= gey ? LW'(ry2 - {1'b0, den_reg}) : ry2[LW-1:0];
            qx_reg   <= {qx_reg[QW-2:0], gex};
            qy_reg   <= {qy_reg[QW-2:0], gey};
        end
        if (cmd.load_out)
        begin
            if (cnt_reg == '0)
            begin
                opx_reg   <= '0;
                opy_reg   <= '0;
                odx_reg   <= '0;
                ody_reg   <= '0;
                ofin_reg  <= 1'b0;
                oleft_reg <= '0;
                ostat_reg <= ppf_pkg::STAT_EMPTY;
            end
            else
            begin
                opx_reg   <= ipx;
                opy_reg   <= ipy;
                odx_reg   <= dx_reg;
                ody_reg   <= dy_reg;
                ofin_reg  <= fin_reg;
                oleft_reg <= left_val;
                ostat_reg <= full_reg ? ppf_pkg::STAT_FULL : ppf_pkg::STAT_OK;
            end
        end
    end

    assign pos_x          = opx_reg;
    assign pos_y          = opy_reg;
    assign dir_x          = odx_reg;
    assign dir_y          = ody_reg;
    assign route_finished = ofin_reg;
    assign distance_left  = oleft_reg;
    assign status         = ostat_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_pt |-> (cnt_reg < CW'(ppf_pkg::MAX_POINTS)))
        else $error("point written into a full store");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.compare |-> ((lo_reg < hi_reg) && (hi_reg <= cnt_reg)))
        else $error("search window out of order");

    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (remx_reg < den_reg) && (remy_reg < den_reg))
        else $error("divider remainder not below divisor");

endmodule

// ===== tb/polyline_path_follower_tb.sv =====
// Self-checking testbench for the polyline path follower: directed table, random routes, scoreboard.
module polyline_path_follower_tb;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [16:0] dir_x;
        logic [16:0] dir_y;
        logic        finished;
        logic [33:0] left;
        logic [1:0]  status;
    } follow_res_t;

    typedef struct {
        logic [1:0]         req;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               first;
        logic [15:0]        ts;
        bit                 typed;
    } stim_row_t;

    logic          clk = 0;
    logic          rst_n = 0;
    logic          s_tvalid = 0;
    logic          s_tready;
    logic [47:0]   s_tdata = '0;
    logic [2:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 0;
    logic [119:0]  m_tdata;
    logic [0:0]    m_tuser;
    logic          cfg_valid = 0;
    logic          cfg_ready;
    logic [ppf_pkg::VEL_W-1:0] cfg_data = '0;

    polyline_path_follower u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Predictor state.
    logic [15:0] way_x_mem [ppf_pkg::MAX_POINTS];
    logic [15:0] way_y_mem [ppf_pkg::MAX_POINTS];
    longint      cum_len [ppf_pkg::MAX_POINTS];
    int          n_points = 0;
    longint      travel = 0;
    bit          backward = 0;
    longint      speed = 0;

    follow_res_t expected_q [$];
    int          errors = 0;
    int          sent = 0;
    bit          send_idle = 1;
    bit          recv_idle = 1;
    bit          pressure_req = 0;
    int          hold_left = 0;

    localparam longint TRAV_HI = (64'sd1 <<< 35) - 1;
    localparam longint TRAV_LO = -(64'sd1 <<< 35);
    localparam longint LEN_TOP = (64'sd1 <<< 34) - 1;

    function automatic longint sat_travel(longint v);
        if (v > TRAV_HI) return TRAV_HI;
        if (v < TRAV_LO) return TRAV_LO;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int slot(int i);
        return backward ? n_points - 1 - i : i;
    endfunction

    function automatic longint wx(int i);
        return longint'($signed(way_x_mem[slot(i)]));
    endfunction

    function automatic longint wy(int i);
        return longint'($signed(way_y_mem[slot(i)]));
    endfunction

    function automatic longint route_total();
        return n_points ? cum_len[n_points - 1] : 0;
    endfunction

    function automatic longint arc_at(int i);
        if (backward) return route_total() - cum_len[n_points - 1 - i];
        return cum_len[i];
    endfunction

    function automatic longint interp(longint start, longint d, longint num, longint den);
        longint unsigned mag = d < 0 ? -d : d;
        longint unsigned q;
        q = den > 0 ? ((mag * longint'(num)) << ppf_pkg::FRAC_W) / longint'(den) : 0;
        return d < 0 ? (start <<< ppf_pkg::FRAC_W) - longint'(q)
                     : (start <<< ppf_pkg::FRAC_W) + longint'(q);
    endfunction

    function automatic follow_res_t follow_step(logic [1:0] req, logic signed [15:0] x,
                                                logic signed [15:0] y, logic first,
                                                logic [15:0] ts);
        follow_res_t r;
        longint ox = 0, oy = 0, dx = 0, dy = 0, left = 0;
        longint ex, ey, c, t, tot, l0, l1, num, den;
        longint unsigned seg;
        int k;
        r = '0;
        r.status = ppf_pkg::STAT_OK;
        if (req == ppf_pkg::REQ_LOAD)
        begin
            if (first)
            begin
                n_points = 0;
                travel = 0;
                backward = 0;
            end
            if (n_points >= ppf_pkg::MAX_POINTS)
            begin
                r.status = ppf_pkg::STAT_FULL;
            end
            else
            begin
                way_x_mem[n_points] = x;
                way_y_mem[n_points] = y;
                if (n_points == 0)
                begin
                    cum_len[0] = 0;
                end
                else
                begin
                    ex = longint'(x) - longint'($signed(way_x_mem[n_points - 1]));
                    ey = longint'(y) - longint'($signed(way_y_mem[n_points - 1]));
                    seg = int_sqrt(longint'(ex * ex + ey * ey) << (2 * ppf_pkg::FRAC_W));
                    c = cum_len[n_points - 1];
                    c = (seg > LEN_TOP - c) ? LEN_TOP : c + longint'(seg);
                    cum_len[n_points] = c;
                end
                n_points++;
            end
        end
        else if (req == ppf_pkg::REQ_ADVANCE)
        begin
            travel = sat_travel(travel + ((speed * longint'({48'd0, ts})) >>> ppf_pkg::FRAC_W));
        end
        else if (req == ppf_pkg::REQ_REVERSE)
        begin
            if (n_points > 0)
            begin
                travel = sat_travel(route_total() - travel);
                backward = !backward;
            end
        end
        if (n_points == 0)
        begin
            r.status = ppf_pkg::STAT_EMPTY;
            return r;
        end
        t = travel;
        tot = route_total();
        k = 0;
        while (k < n_points && arc_at(k) < t) k++;
        if (k == 0)
        begin
            ox = wx(0) <<< ppf_pkg::FRAC_W;
            oy = wy(0) <<< ppf_pkg::FRAC_W;
            if (n_points > 1)
            begin
                dx = wx(1) - wx(0);
                dy = wy(1) - wy(0);
            end
        end
        else if (k == n_points)
        begin
            ox = wx(k - 1) <<< ppf_pkg::FRAC_W;
            oy = wy(k - 1) <<< ppf_pkg::FRAC_W;
            r.finished = 1;
        end
        else
        begin
            l0 = arc_at(k - 1);
            l1 = arc_at(k);
            num = t - l0;
            den = l1 - l0;
            if (num < 0) num = 0;
            if (num > den) num = den;
            dx = wx(k) - wx(k - 1);
            dy = wy(k) - wy(k - 1);
            ox = interp(wx(k - 1), dx, num, den);
            oy = interp(wy(k - 1), dy, num, den);
        end
        left = tot - t;
        if (left < 0) left = 0;
        if (left > LEN_TOP) left = LEN_TOP;
        r.pos_x = ox[23:0];
        r.pos_y = oy[23:0];
        r.dir_x = dx[16:0];
        r.dir_y = dy[16:0];
        r.left = left[33:0];
        return r;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("MISMATCH %s: got %h expected %h", field, got, want);
        errors++;
    endtask

    // Called at a falling edge; returns at a falling edge with the beat withdrawn.
    task automatic send_item(logic [1:0] req, logic signed [15:0] x, logic signed [15:0] y,
                             logic first, logic [15:0] ts, bit typed);
        int g;
        follow_res_t r;
        g = send_idle ? $urandom_range(0, 10) : 0;
        if (g > 0)
        begin
            s_tvalid = 0;
            repeat (g) @(negedge clk);
        end
        s_tdata = {ts, y, x};
        s_tuser = {first, req};
        s_tvalid = 1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        r = follow_step(req, x, y, first, ts);
        if (typed)
        begin
            r = '0;
            r.status = ppf_pkg::STAT_EMPTY;
        end
        expected_q = {expected_q, r};
        sent++;
        @(negedge clk);
        s_tvalid = 0;
    endtask

    task automatic write_velocity(logic [ppf_pkg::VEL_W-1:0] v);
        while (expected_q.size() != 0) @(negedge clk);
        s_tvalid = 0;
        repeat (150) @(negedge clk);
        cfg_data = v;
        cfg_valid = 1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        speed = longint'($signed(v));
        @(negedge clk);
        cfg_valid = 0;
    endtask

    function automatic logic signed [15:0] pick_coord(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 400) - 200);
            1: return 16'($urandom());
            default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    function automatic logic [15:0] pick_step();
        if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        return 16'($urandom() >> $urandom_range(16, 32));
    endfunction

    task automatic run_route(int npts, int nops);
        int mode;
        int op;
        mode = $urandom_range(0, 5) < 4 ? 0 : $urandom_range(1, 2);
        for (int i = 0; i < npts; i++)
            send_item(ppf_pkg::REQ_LOAD, pick_coord(mode), pick_coord(mode), i == 0,
                      16'($urandom()), 1'b0);
        for (int i = 0; i < nops; i++)
        begin
            op = $urandom_range(0, 19);
            if (op < 12)
                send_item(ppf_pkg::REQ_ADVANCE, 16'($urandom()), 16'($urandom()),
                          1'($urandom()), pick_step(), 1'b0);
            else if (op < 16)
                send_item(ppf_pkg::REQ_REVERSE, 16'($urandom()), 16'($urandom()),
                          1'($urandom()), 16'($urandom()), 1'b0);
            else if (op < 18)
                send_item(ppf_pkg::REQ_LOAD, pick_coord(mode), pick_coord(mode), 1'b0,
                          16'($urandom()), 1'b0);
            else if (op < 19)
                send_item(REQ_UNKNOWN, 16'($urandom()), 16'($urandom()),
                          1'($urandom()), 16'($urandom()), 1'b0);
            else
                send_item(ppf_pkg::REQ_LOAD, pick_coord(mode), pick_coord(mode), 1'b1,
                          16'($urandom()), 1'b0);
        end
    endtask

    stim_row_t dir_table [24] = '{
        '{ppf_pkg::REQ_ADVANCE, 16'sh0000, 16'sh0000, 1'b0, 16'hffff, 1'b1},
        '{ppf_pkg::REQ_REVERSE, 16'sh7fff, 16'sh8000, 1'b1, 16'h0000, 1'b1},
        '{REQ_UNKNOWN,          16'sh8000, 16'sh7fff, 1'b1, 16'hffff, 1'b1},
        '{ppf_pkg::REQ_LOAD,    16'sh0010, 16'sh0020, 1'b1, 16'h0000, 1'b0},
        '{ppf_pkg::REQ_REVERSE, 16'sh0000, 16'sh0000, 1'b0, 16'h0000, 1'b0},
        '{ppf_pkg::REQ_ADVANCE, 16'sh0000, 16'sh0000, 1'b0, 16'h0100, 1'b0},
        '{ppf_pkg::REQ_LOAD,    16'sh8000, 16'sh8000, 1'b1, 16'hffff, 1'b0},
        '{ppf_pkg::REQ_LOAD,    16'sh7fff, 16'sh7fff, 1'b0, 16'h0000, 1'b0},
        '{ppf_pkg::REQ_LOAD,    16'sh7fff, 16'sh8000, 1'b0, 16'h0000, 1'b0},
        '{ppf_pkg::REQ_ADVANCE, 16'sh0000, 16'sh0000, 1'b0, 16'h0000, 1'b0},
        '{ppf_pkg::REQ_ADVANCE, 16'sh0000, 16'sh0000, 1'b0, 16'hffff, 1'b0},
        '{ppf_pkg::REQ_ADVANCE, 16'sh0000, 16'sh0000, 1'b0, 16'hffff, 1'b0},
        '{ppf_pkg::REQ_REVERSE, 16'sh0000, 16'sh0000, 1'b0, 16'h0000, 1'b0},
        '{ppf_pkg::REQ_ADVANCE, 16'sh0000, 16'sh0000, 1'b0, 16'h8000, 1'b0},
        '{ppf_pkg::REQ_LOAD,    16'sh0000, 16'sh0000, 1'b0, 16'h0000, 1'b0},
        '{REQ_UNKNOWN,          16'sh0000, 16'sh0000, 1'b0, 16'h0000, 1'b0},
        '{ppf_pkg::REQ_REVERSE, 16'sh0000, 16'sh0000, 1'b0, 16'h0000, 1'b0},
        '{ppf_pkg::REQ_ADVANCE, 16'sh0000, 16'sh0000, 1'b0, 16'hffff, 1'b0},
        '{ppf_pkg::REQ_ADVANCE, 16'sh0000, 16'sh0000, 1'b0, 16'hffff, 1'b0},
        '{ppf_pkg::REQ_LOAD,    16'sh0003, 16'sh0004, 1'b1, 16'h0000, 1'b0},
        '{ppf_pkg::REQ_ADVANCE, 16'sh0000, 16'sh0000, 1'b0, 16'h0200, 1'b0},
        '{ppf_pkg::REQ_REVERSE, 16'sh0000, 16'sh0000, 1'b0, 16'h0000, 1'b0},
        '{ppf_pkg::REQ_LOAD,    16'sh0006, 16'sh0008, 1'b0, 16'h0000, 1'b0},
        '{ppf_pkg::REQ_ADVANCE, 16'sh0000, 16'sh0000, 1'b0, 16'h0080, 1'b0}
    };

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready = 0;
            hold_left--;
        end
        else
        begin
            m_tready = 1;
        end
    end

    always @(posedge clk)
    begin
        follow_res_t w;
        if (m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                report("unexpected result beat", longint'(m_tdata[23:0]), 0);
            end
            else
            begin
                w = expected_q.pop_front();
                if (m_tdata[23:0] !== w.pos_x) report("pos_x", m_tdata[23:0], w.pos_x);
                if (m_tdata[47:24] !== w.pos_y) report("pos_y", m_tdata[47:24], w.pos_y);
                if (m_tdata[64:48] !== w.dir_x) report("dir_x", m_tdata[64:48], w.dir_x);
                if (m_tdata[81:65] !== w.dir_y) report("dir_y", m_tdata[81:65], w.dir_y);
                if (m_tdata[115:82] !== w.left) report("distance_left", m_tdata[115:82], w.left);
                if (m_tdata[117:116] !== w.status)
                    report("status", m_tdata[117:116], w.status);
                if (m_tuser[0] !== w.finished) report("route_finished", m_tuser[0], w.finished);
            end
            if (pressure_req)
            begin
                pressure_req = 0;
                hold_left = 3000;
            end
            else
            begin
                hold_left = recv_idle ? $urandom_range(0, 10) : 0;
            end
        end
    end

    initial
    begin
        #(12 * 3000000);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [ppf_pkg::VEL_W-1:0] speeds [7];
        int goal;
        speeds = '{24'h7fffff, 24'h800000, 24'h000000, 24'h000100, 24'hfffd44, 24'h0, 24'h0};
        speeds[5] = 24'($urandom());
        speeds[6] = 24'($urandom());
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        foreach (dir_table[i])
        begin
            if (i == 3) write_velocity(24'h0003e8);
            send_item(dir_table[i].req, dir_table[i].x, dir_table[i].y, dir_table[i].first,
                      dir_table[i].ts, dir_table[i].typed);
        end
        for (int p = 0; p < 7; p++)
        begin
            write_velocity(speeds[p]);
            goal = sent + 240;
            send_idle = (p != 3);
            recv_idle = (p != 4);
            if (p == 1) pressure_req = 1;
            if (p == 5) run_route(262, 12);
            if (p == 0)
            begin
                run_route(3, 0);
                for (int i = 0; i < 40; i++)
                    send_item(ppf_pkg::REQ_ADVANCE, 16'sh0000, 16'sh0000, 1'b0, 16'hffff, 1'b0);
                send_item(ppf_pkg::REQ_REVERSE, 16'sh0000, 16'sh0000, 1'b0, 16'h0000, 1'b0);
                send_item(ppf_pkg::REQ_REVERSE, 16'sh0000, 16'sh0000, 1'b0, 16'h0000, 1'b0);
            end
            while (sent < goal) run_route($urandom_range(1, 8), $urandom_range(2, 30));
        end
        s_tvalid = 0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ppf_pkg.sv
hw/rtl/ppf_ctrl.sv
hw/rtl/ppf_dp.sv
hw/rtl/polyline_path_follower.sv
tb/polyline_path_follower_tb.sv
